@@ rtl/core/rdx_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdx_pkg: shared definitions for the radix ascii converter
// Widths, divider sizing, character codes and the digit-to-ascii mapping.
// ----------------------------------------------------------------------------
package rdx_pkg;

  // magnitude width; the signed input is one bit wider
  localparam int MAG_BITS   = 32;
  localparam int NUM_W      = MAG_BITS + 1;
  localparam int RADIX_W    = 5;
  localparam int DIGIT_W    = 4;
  localparam int CHAR_W     = 8;

  // divider retires DIV_BITS quotient bits per cycle
  localparam int DIV_BITS   = 4;
  localparam int DIV_CYCLES = (MAG_BITS + DIV_BITS - 1) / DIV_BITS;
  localparam int DIV_W      = DIV_CYCLES * DIV_BITS;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

  // digit stack holds at most one digit per magnitude bit (radix two)
  localparam int STK_DEPTH  = MAG_BITS;
  localparam int STK_CNT_W  = $clog2(STK_DEPTH + 1);

  // radix limits
  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

  // character codes
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LOW_A   = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOW_F   = 8'h66;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ALPHA_OFS = CH_LOW_A - 8'd10;

  // digit stack control
  typedef struct packed {
    logic                push;
    logic                pop;
    logic [DIGIT_W-1:0]  digit;
  } stk_ctl_t;

  // digit value to ascii, lower-case letters above nine
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] ext;
    ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    if (d < 4'd10) begin
      return CH_ZERO + ext;
    end else begin
      return CH_ALPHA_OFS + ext;
    end
  endfunction

endpackage

@@ rtl/core/rdx_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdx_div: iterative restoring divider
// Divides the magnitude by the radix, DIV_BITS quotient bits per cycle.
// ----------------------------------------------------------------------------
module rdx_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [rdx_pkg::MAG_BITS-1:0]        dividend,
  input  logic [rdx_pkg::RADIX_W-1:0]         divisor,
  output logic                                done,
  output logic [rdx_pkg::MAG_BITS-1:0]        quotient,
  output logic [rdx_pkg::DIGIT_W-1:0]         remainder
);

  logic [rdx_pkg::DIV_W-1:0]     quo_r, quo_nxt;
  logic [rdx_pkg::DIGIT_W-1:0]   rem_r, rem_nxt;
  logic [rdx_pkg::RADIX_W-1:0]   dvs_r, dvs_nxt;
  logic [rdx_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [rdx_pkg::DIV_W-1:0]     step_q;
  logic [rdx_pkg::DIGIT_W-1:0]   step_r;

  // shift-compare-subtract, DIV_BITS times per cycle
  always_comb begin
    logic [rdx_pkg::RADIX_W-1:0] t;
    step_q = quo_r;
    step_r = rem_r;
    t      = '0;
    for (int k = 0; k < rdx_pkg::DIV_BITS; k++) begin
      t      = {step_r, step_q[rdx_pkg::DIV_W-1]};
      step_q = {step_q[rdx_pkg::DIV_W-2:0], 1'b0};
      if (t >= dvs_r) begin
        t         = t - dvs_r;
        step_q[0] = 1'b1;
      end
      step_r = t[rdx_pkg::DIGIT_W-1:0];
    end
  end

  // sequencing of the divide
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = rdx_pkg::DIV_W'(dividend);
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = step_q;
      rem_nxt = step_r;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == rdx_pkg::DIV_CNT_W'(rdx_pkg::DIV_CYCLES - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r[rdx_pkg::MAG_BITS-1:0];
  assign remainder = rem_r;

endmodule

@@ rtl/core/rdx_stack.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdx_stack: digit stack
// Shift-register stack that reverses the digit order, top at entry zero.
// ----------------------------------------------------------------------------
module rdx_stack (
  input  logic                             clk,
  input  logic                             rst_n,
  input  rdx_pkg::stk_ctl_t                ctl,
  output logic [rdx_pkg::DIGIT_W-1:0]      top,
  output logic [rdx_pkg::STK_CNT_W-1:0]    count
);

  logic [rdx_pkg::DIGIT_W-1:0]   ent_r   [rdx_pkg::STK_DEPTH];
  logic [rdx_pkg::DIGIT_W-1:0]   ent_nxt [rdx_pkg::STK_DEPTH];
  logic [rdx_pkg::STK_CNT_W-1:0] cnt_r, cnt_nxt;

  // push shifts down, pop shifts up
  always_comb begin
    for (int i = 0; i < rdx_pkg::STK_DEPTH; i++) begin
      ent_nxt[i] = ent_r[i];
    end
    cnt_nxt = cnt_r;
    if (ctl.push) begin
      ent_nxt[0] = ctl.digit;
      for (int i = 1; i < rdx_pkg::STK_DEPTH; i++) begin
        ent_nxt[i] = ent_r[i-1];
      end
      cnt_nxt = cnt_r + 1'b1;
    end else if (ctl.pop) begin
      for (int i = 0; i < rdx_pkg::STK_DEPTH - 1; i++) begin
        ent_nxt[i] = ent_r[i+1];
      end
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // entries
  always_ff @(posedge clk) begin
    for (int i = 0; i < rdx_pkg::STK_DEPTH; i++) begin
      ent_r[i] <= ent_nxt[i];
    end
  end

  assign top   = ent_r[0];
  assign count = cnt_r;

endmodule

@@ rtl/core/integer_to_radix_ascii.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_radix_ascii: signed integer to ascii text in radix 2 to 16
// Emits one character per transaction, most significant digit first.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------
//   in      | input     | in_valid / in_ready   | in_number[32:0], in_radix[4:0]
//   out     | output    | out_valid / out_ready | out_char_code[7:0], out_last
//
// each digit takes one pass of the shared divider (four quotient bits per
// cycle); the characters then leave at one per cycle while out_ready is high.
// in_ready is high only while idle; a new item is taken while the final
// character still waits in the output register. out_ready low stalls the
// character stream. synchronous active-low reset clears all control state.
//
module integer_to_radix_ascii (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [rdx_pkg::NUM_W-1:0]     in_number,
  input  logic [rdx_pkg::RADIX_W-1:0]          in_radix,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [rdx_pkg::CHAR_W-1:0]           out_char_code,
  output logic                                 out_last
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_SIGN = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t                          state_r, state_nxt;
  logic                            neg_r, neg_nxt;
  logic [rdx_pkg::RADIX_W-1:0]     radix_r, radix_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [rdx_pkg::CHAR_W-1:0]      out_char_code_r, out_char_code_nxt;
  logic                            out_last_r, out_last_nxt;

  logic                            accept;
  logic                            load_out;
  logic [rdx_pkg::MAG_BITS-1:0]    low;
  logic [rdx_pkg::MAG_BITS-1:0]    mag;
  logic [rdx_pkg::RADIX_W-1:0]     radix_clamp;

  logic                            div_start;
  logic [rdx_pkg::MAG_BITS-1:0]    div_dividend;
  logic [rdx_pkg::RADIX_W-1:0]     div_divisor;
  logic                            div_done;
  logic [rdx_pkg::MAG_BITS-1:0]    div_quo;
  logic [rdx_pkg::DIGIT_W-1:0]     div_rem;
  logic                            quo_zero;

  rdx_pkg::stk_ctl_t               stk_ctl;
  logic [rdx_pkg::DIGIT_W-1:0]     stk_top;
  logic [rdx_pkg::STK_CNT_W-1:0]   stk_count;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign load_out = !out_valid_r || out_ready;
  assign quo_zero = (div_quo == '0);

  // magnitude, most negative value saturates to all ones
  assign low = in_number[rdx_pkg::MAG_BITS-1:0];
  always_comb begin
    if (in_number[rdx_pkg::MAG_BITS]) begin
      mag = (low == '0) ? '1 : (~low + 1'b1);
    end else begin
      mag = low;
    end
  end

  // radix clamp to 2..16
  always_comb begin
    priority if (in_radix < rdx_pkg::RADIX_MIN) begin
      radix_clamp = rdx_pkg::RADIX_MIN;
    end else if (in_radix > rdx_pkg::RADIX_MAX) begin
      radix_clamp = rdx_pkg::RADIX_MAX;
    end else begin
      radix_clamp = in_radix;
    end
  end

  // divider launch: first digit on accept, then on every nonzero quotient
  assign div_start    = accept || ((state_r == S_DIV) && div_done && !quo_zero);
  assign div_dividend = accept ? mag : div_quo;
  assign div_divisor  = accept ? radix_clamp : radix_r;

  rdx_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // stack control
  always_comb begin
    stk_ctl.push  = (state_r == S_DIV) && div_done;
    stk_ctl.pop   = (state_r == S_EMIT) && load_out;
    stk_ctl.digit = div_rem;
  end

  rdx_stack u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (stk_ctl),
    .top   (stk_top),
    .count (stk_count)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    neg_nxt   = neg_r;
    radix_nxt = radix_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          neg_nxt   = in_number[rdx_pkg::MAG_BITS];
          radix_nxt = radix_clamp;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done && quo_zero) begin
          state_nxt = neg_r ? S_SIGN : S_EMIT;
        end
      end
      S_SIGN: begin
        if (load_out) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (load_out && (stk_count == rdx_pkg::STK_CNT_W'(1))) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt     = out_valid_r && !out_ready;
    out_char_code_nxt = out_char_code_r;
    out_last_nxt      = out_last_r;
    if (load_out && (state_r == S_SIGN)) begin
      out_valid_nxt     = 1'b1;
      out_char_code_nxt = rdx_pkg::CH_MINUS;
      out_last_nxt      = 1'b0;
    end else if (load_out && (state_r == S_EMIT)) begin
      out_valid_nxt     = 1'b1;
      out_char_code_nxt = rdx_pkg::digit_char(stk_top);
      out_last_nxt      = (stk_count == rdx_pkg::STK_CNT_W'(1));
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    neg_r           <= neg_nxt;
    radix_r         <= radix_nxt;
    out_char_code_r <= out_char_code_nxt;
    out_last_r      <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_code_r;
  assign out_last      = out_last_r;

endmodule

@@ rtl/core/rdx_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdx_checker: port-level checks for the radix ascii converter
// Watches the handshakes and the character stream; bound to the top level.
// ----------------------------------------------------------------------------
module rdx_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic [rdx_pkg::CHAR_W-1:0]           out_char_code,
  input  logic                                 out_last
);

  // stalled output transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char_code) && $stable(out_last))
    else $error("output transaction changed while stalled");

  // block is busy right after taking an input transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after a transaction");

  // a minus sign never ends a number
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_char_code == rdx_pkg::CH_MINUS) |-> !out_last)
    else $error("minus sign marked as last character");

  // only sign, decimal digits or lower-case a to f leave the block
  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_char_code == rdx_pkg::CH_MINUS) ||
                  ((out_char_code >= rdx_pkg::CH_ZERO) && (out_char_code <= rdx_pkg::CH_NINE)) ||
                  ((out_char_code >= rdx_pkg::CH_LOW_A) && (out_char_code <= rdx_pkg::CH_LOW_F)))
    else $error("character outside the digit set");

  // output is empty after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind integer_to_radix_ascii rdx_checker u_rdx_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_char_code (out_char_code),
  .out_last      (out_last)
);

@@ bench/radix_text_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_text_checker: expected-text predictor and scoreboard
// Watches both channels of integer_to_radix_ascii. Every accepted number is
// turned into the characters it should produce, and every accepted character
// is compared in order against that text.
// ----------------------------------------------------------------------------
module radix_text_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [rdx_pkg::NUM_W-1:0]         in_number,
  input  logic [rdx_pkg::RADIX_W-1:0]       in_radix,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [rdx_pkg::CHAR_W-1:0]        out_char_code,
  input  logic                              out_last,
  output int                                fail_count,
  output int                                chars_pending
);

  localparam logic [63:0] MAG_MAX = (64'd1 << rdx_pkg::MAG_BITS) - 64'd1;

  typedef struct packed {
    logic [rdx_pkg::CHAR_W-1:0] code;
    logic                       last;
  } text_char_t;

  text_char_t expected_text[$];
  text_char_t want;

  // characters of one number, sign first, most significant digit next
  function automatic void predict_text(input logic [rdx_pkg::NUM_W-1:0] number,
                                       input logic [rdx_pkg::RADIX_W-1:0] radix);
    logic [63:0]                 mag;
    logic [63:0]                 base;
    logic [rdx_pkg::DIGIT_W-1:0] digit_buf [0:63];
    logic                        neg;
    int                          ndig;
    text_char_t                  ch;
    neg  = number[rdx_pkg::NUM_W-1];
    ndig = 0;
    // magnitude, with the most negative value saturated
    if (neg) begin
      mag = (64'd1 << rdx_pkg::MAG_BITS) - 64'(number[rdx_pkg::MAG_BITS-1:0]);
      if (mag > MAG_MAX) begin
        mag = MAG_MAX;
      end
    end else begin
      mag = 64'(number[rdx_pkg::MAG_BITS-1:0]);
    end
    // out-of-range radix clamps to the nearest legal base
    base = 64'(radix);
    if (radix < rdx_pkg::RADIX_MIN) begin
      base = 64'(rdx_pkg::RADIX_MIN);
    end else if (radix > rdx_pkg::RADIX_MAX) begin
      base = 64'(rdx_pkg::RADIX_MAX);
    end
    // least significant digit first; zero still yields one digit
    do begin
      digit_buf[ndig] = rdx_pkg::DIGIT_W'(mag % base);
      mag = mag / base;
      ndig++;
    end while (mag != 64'd0);
    if (neg) begin
      ch.code = rdx_pkg::CH_MINUS;
      ch.last = 1'b0;
      expected_text.push_back(ch);
    end
    for (int i = ndig - 1; i >= 0; i--) begin
      if (digit_buf[i] < 4'd10) begin
        ch.code = rdx_pkg::CH_ZERO + rdx_pkg::CHAR_W'(digit_buf[i]);
      end else begin
        ch.code = rdx_pkg::CH_LOW_A + rdx_pkg::CHAR_W'(digit_buf[i]) - 8'd10;
      end
      ch.last = (i == 0);
      expected_text.push_back(ch);
    end
  endfunction

  // record one failure, printing only the first few
  task automatic note_failure(input string what);
    if (fail_count < 10) begin
      $display("%0t ns: %s", $time, what);
    end
    fail_count++;
  endtask

  // predict on input transactions, compare on output transactions
  always @(posedge clk) begin
    if (!rst_n) begin
      chars_pending <= 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_text(in_number, in_radix);
      end
      if (out_valid && out_ready) begin
        if (expected_text.size() == 0) begin
          note_failure($sformatf("unexpected char %h last %b", out_char_code, out_last));
        end else begin
          want = expected_text.pop_front();
          if (want.code !== out_char_code || want.last !== out_last) begin
            note_failure($sformatf("char expected %h got %h, last expected %b got %b",
                                   want.code, out_char_code, want.last, out_last));
          end
        end
      end
      chars_pending <= expected_text.size();
    end
  end

endmodule

@@ bench/integer_to_radix_ascii_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_radix_ascii_tb: top level testbench
// Drives directed and random numbers into the converter under varying idle
// patterns on both channels, including a long output stall, and reports the
// verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module integer_to_radix_ascii_tb;

  localparam int STALL_CYCLES = 600;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  logic [rdx_pkg::NUM_W-1:0]      in_number;
  logic [rdx_pkg::RADIX_W-1:0]    in_radix;
  logic                           out_valid;
  logic                           out_ready;
  logic [rdx_pkg::CHAR_W-1:0]     out_char_code;
  logic                           out_last;

  int fail_count;
  int chars_pending;
  int send_idle_pct;
  int recv_idle_pct;
  bit stall_request;

  integer_to_radix_ascii dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_number     (in_number),
    .in_radix      (in_radix),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char_code (out_char_code),
    .out_last      (out_last)
  );

  radix_text_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_number     (in_number),
    .in_radix      (in_radix),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char_code (out_char_code),
    .out_last      (out_last),
    .fail_count    (fail_count),
    .chars_pending (chars_pending)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  initial begin
    #(80_000_000);
    $display("CHECK FAILED");
    $finish;
  end

  // receiver: random back-pressure, or a long hold-off on request
  initial begin
    bit stall_served;
    stall_served = 1'b0;
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (stall_request && !stall_served) begin
        stall_served = 1'b1;
        out_ready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
      @(posedge clk);
    end
  end

  // offer one number, idling first at random, and wait for its transaction
  task automatic send_number(input logic [rdx_pkg::NUM_W-1:0] number,
                             input logic [rdx_pkg::RADIX_W-1:0] radix);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_number <= number;
    in_radix  <= radix;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop sending and wait for every expected character
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    @(posedge clk);
    while (chars_pending != 0) @(posedge clk);
  endtask

  // mostly legal bases, sometimes out of range to hit the clamps
  function automatic logic [rdx_pkg::RADIX_W-1:0] pick_radix();
    if ($urandom_range(99) < 88) begin
      return rdx_pkg::RADIX_W'($urandom_range(2, 16));
    end
    return rdx_pkg::RADIX_W'($urandom_range(0, 31));
  endfunction

  // numbers from several shapes: full range, small, powers of the base, extremes, shifted
  function automatic logic [rdx_pkg::NUM_W-1:0] pick_number(
      input logic [rdx_pkg::RADIX_W-1:0] radix);
    longint unsigned mag;
    longint unsigned pw;
    longint unsigned r;
    int              k;
    bit              neg;
    neg = 1'($urandom_range(1));
    case ($urandom_range(6))
      0: return {1'($urandom_range(1)), 32'($urandom())};
      1: mag = 64'($urandom_range(0, 300));
      2: begin
        r = (radix < rdx_pkg::RADIX_MIN) ? 64'd2 :
            (radix > rdx_pkg::RADIX_MAX) ? 64'd16 : 64'(radix);
        pw = 64'd1;
        k = int'($urandom_range(0, 31));
        while (k > 0 && pw * r < (64'd1 << rdx_pkg::MAG_BITS)) begin
          pw = pw * r;
          k--;
        end
        mag = pw + 64'($urandom_range(0, 2)) - 64'd1;
      end
      3: begin
        case ($urandom_range(3))
          0: return 33'h1_0000_0000;
          1: return 33'h1_0000_0001;
          2: return 33'h0_ffff_ffff;
          default: return 33'h0_0000_0000;
        endcase
      end
      4: mag = 64'(32'($urandom()) >> $urandom_range(31));
      default: mag = 64'($urandom());
    endcase
    if (neg) begin
      return rdx_pkg::NUM_W'(0) - {1'b0, mag[rdx_pkg::MAG_BITS-1:0]};
    end
    return {1'b0, mag[rdx_pkg::MAG_BITS-1:0]};
  endfunction

  // random numbers under one idle pattern
  task automatic run_random(input int n_items, input int snd_pct, input int rcv_pct);
    logic [rdx_pkg::RADIX_W-1:0] r;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    repeat (n_items) begin
      r = pick_radix();
      send_number(pick_number(r), r);
    end
  endtask

  // stimulus and verdict
  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_number     = '0;
    in_radix      = '0;
    stall_request = 1'b0;
    send_idle_pct = 37;
    recv_idle_pct = 83;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero, unit values, extremes, letter digits, radix clamps
    send_number(33'h0_0000_0000, 5'd10);
    send_number(33'h0_0000_0001, 5'd2);
    send_number(33'h1_ffff_ffff, 5'd10);
    send_number(33'h0_ffff_ffff, 5'd2);
    send_number(33'h0_ffff_ffff, 5'd10);
    send_number(33'h0_ffff_ffff, 5'd3);
    send_number(33'h1_0000_0000, 5'd16);
    send_number(33'h1_0000_0000, 5'd2);
    send_number(33'h1_0000_0001, 5'd16);
    send_number(33'h1_8000_0000, 5'd10);
    send_number(33'h0_00ab_cdef, 5'd16);
    send_number(33'h0_0000_00ff, 5'd16);
    send_number(33'h0_0000_000f, 5'd16);
    send_number(33'h0_0000_0010, 5'd16);
    send_number(33'h0_0000_000a, 5'd10);
    send_number(33'h0_0000_0064, 5'd0);
    send_number(33'h0_0000_0064, 5'd1);
    send_number(33'h0_0000_0064, 5'd17);
    send_number(33'h1_ffff_ff9c, 5'd31);
    send_number(33'h0_0000_0000, 5'd31);
    send_number(33'h0_1234_5678, 5'd7);
    send_number(33'h1_edcb_a988, 5'd13);
    wait_drain();

    // two idle patterns, pausing in between until all text is out
    run_random(160, 37, 83);
    wait_drain();
    run_random(160, 83, 37);
    wait_drain();

    // long receiver hold-off while numbers keep coming
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_request = 1'b1;
    run_random(20, 0, 0);
    run_random(160, 0, 0);
    wait_drain();

    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
